/* rtl/sm83_pkg.sv */
// ============================================================================
// sm83_pkg
// shared types, instruction codes and timing tables for the sm83 opcode decoder
// ============================================================================
package sm83_pkg;

    localparam int unsigned CODE_W = 7;

    typedef logic [CODE_W-1:0] code_t;

    // instruction codes in table order
    localparam code_t I_NOP        = 7'd0;
    localparam code_t I_INC_R8     = 7'd1;
    localparam code_t I_DEC_R8     = 7'd2;
    localparam code_t I_INC_R16    = 7'd3;
    localparam code_t I_DEC_R16    = 7'd4;
    localparam code_t I_ADD_HL     = 7'd5;
    localparam code_t I_LD_R16_N16 = 7'd6;
    localparam code_t I_LD_R8_N8   = 7'd7;
    localparam code_t I_LD_R16M_A  = 7'd8;
    localparam code_t I_LD_A_R16M  = 7'd9;
    localparam code_t I_LD_N16M_SP = 7'd10;
    localparam code_t I_RLCA       = 7'd11;
    localparam code_t I_RRCA       = 7'd12;
    localparam code_t I_RLA        = 7'd13;
    localparam code_t I_RRA        = 7'd14;
    localparam code_t I_DAA        = 7'd15;
    localparam code_t I_CPL        = 7'd16;
    localparam code_t I_SCF        = 7'd17;
    localparam code_t I_CCF        = 7'd18;
    localparam code_t I_JR         = 7'd19;
    localparam code_t I_JR_CC      = 7'd20;
    localparam code_t I_STOP       = 7'd21;
    localparam code_t I_LD_R8_R8   = 7'd22;
    localparam code_t I_HALT       = 7'd23;
    localparam code_t I_ALU_R8     = 7'd24;  // eight codes, one per alu op
    localparam code_t I_ALU_N8     = 7'd32;  // eight codes, one per alu op
    localparam code_t I_CB_ROT     = 7'd40;  // eight codes for rotates and shifts
    localparam code_t I_BIT        = 7'd48;
    localparam code_t I_RES        = 7'd49;
    localparam code_t I_SET        = 7'd50;
    localparam code_t I_RET_CC     = 7'd51;  // four codes, one per condition
    localparam code_t I_RET        = 7'd55;
    localparam code_t I_RETI       = 7'd56;
    localparam code_t I_JP_CC      = 7'd57;  // four codes
    localparam code_t I_JP         = 7'd61;
    localparam code_t I_JP_HL      = 7'd62;
    localparam code_t I_CALL_CC    = 7'd63;  // four codes
    localparam code_t I_CALL       = 7'd67;
    localparam code_t I_RST        = 7'd68;
    localparam code_t I_POP        = 7'd69;
    localparam code_t I_PUSH       = 7'd70;
    localparam code_t I_LDH_CM_A   = 7'd71;
    localparam code_t I_LDH_N8M_A  = 7'd72;
    localparam code_t I_LD_N16M_A  = 7'd73;
    localparam code_t I_LDH_A_CM   = 7'd74;
    localparam code_t I_LDH_A_N8M  = 7'd75;
    localparam code_t I_LD_A_N16M  = 7'd76;
    localparam code_t I_ADD_SP     = 7'd77;
    localparam code_t I_LD_HL_SP   = 7'd78;
    localparam code_t I_LD_SP_HL   = 7'd79;
    localparam code_t I_DI         = 7'd80;
    localparam code_t I_EI         = 7'd81;
    localparam code_t I_UNKNOWN    = 7'd82;

    // opcode patterns
    localparam logic [7:0] OP_HALT    = 8'h76;
    localparam logic [7:0] MASK_C7    = 8'hC7;
    localparam logic [7:0] MASK_CF    = 8'hCF;
    localparam logic [7:0] PAT_ALU_N8 = 8'hC6;
    localparam logic [7:0] PAT_RST    = 8'hC7;
    localparam logic [7:0] PAT_POP    = 8'hC1;
    localparam logic [7:0] PAT_PUSH   = 8'hC5;

    localparam int unsigned TDATA_W = 40;

    typedef struct packed {
        logic [2:0] bit_or_vector;
        logic [2:0] alu_operation;
        logic [1:0] condition_sel;
        logic [1:0] stack_pair_sel;
        logic [1:0] reg16_sel;
        logic [2:0] reg8_dest;
        logic [2:0] reg8_source;
        logic [2:0] reg8_sel;
        logic       recognized;
        logic [2:0] machine_cycles;
        logic [1:0] length_bytes;
        code_t      instr_code;
    } dec_t;

    function automatic logic [1:0] code_length(input code_t code);
        logic [1:0] len;
        len = 2'd1;
        unique case (code) inside
            I_LD_R16_N16, I_LD_N16M_SP, [I_JP_CC:I_JP], [I_CALL_CC:I_CALL],
            I_LD_N16M_A, I_LD_A_N16M:
                len = 2'd3;
            I_LD_R8_N8, I_JR, I_JR_CC, I_STOP, [I_ALU_N8:I_SET],
            I_LDH_N8M_A, I_LDH_A_N8M, I_ADD_SP, I_LD_HL_SP:
                len = 2'd2;
            default:
                len = 2'd1;
        endcase
        return len;
    endfunction

    function automatic logic [2:0] code_cycles(input code_t code);
        logic [2:0] cyc;
        cyc = 3'd1;
        unique case (code) inside
            I_STOP, I_HALT, I_UNKNOWN:
                cyc = 3'd0;
            I_INC_R16, I_DEC_R16, I_ADD_HL, I_LD_R8_N8, I_LD_R16M_A, I_LD_A_R16M,
            I_JR_CC, [I_ALU_N8:I_SET], [I_RET_CC:I_RET_CC + 7'd3],
            I_LDH_CM_A, I_LDH_A_CM, I_LD_SP_HL:
                cyc = 3'd2;
            I_LD_R16_N16, I_JR, [I_JP_CC:I_JP_CC + 7'd3],
            [I_CALL_CC:I_CALL_CC + 7'd3], I_POP, I_LDH_N8M_A, I_LDH_A_N8M,
            I_LD_HL_SP:
                cyc = 3'd3;
            I_RET, I_RETI, I_JP, I_RST, I_PUSH, I_LD_N16M_A, I_LD_A_N16M, I_ADD_SP:
                cyc = 3'd4;
            I_LD_N16M_SP:
                cyc = 3'd5;
            I_CALL:
                cyc = 3'd6;
            default:
                cyc = 3'd1;
        endcase
        return cyc;
    endfunction

endpackage

/* rtl/sm83_opcode_decoder.sv */
// ============================================================================
// sm83_opcode_decoder
// streaming decoder for sm83 main and cb-prefixed opcode bytes
// ============================================================================
// One opcode item is taken per clock unless stalled, and one result item
// comes out for each: the opcode lands in an input register, the decode
// table sits between it and the result register, and the result register
// holds its item while m_tready is low so that the input side keeps flowing
// until both registers are full. Unknown opcodes (and a bare 0xCB in the
// main table) come out with code 82, length 1, machine_cycles 0, m_tuser low
// and all operand fields zero. No state is kept between items.
module sm83_opcode_decoder (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // opcode_byte
    input  logic                           s_tuser,   // command
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // instr_code, length_bytes, machine_cycles, reg8_sel, reg8_source,
    // reg8_dest, reg16_sel, stack_pair_sel, condition_sel, alu_operation,
    // bit_or_vector, zero fill
    output logic [sm83_pkg::TDATA_W-1:0]   m_tdata,
    output logic                           m_tuser    // recognized
);

    logic           in_valid_reg;
    logic [7:0]     in_op_reg;
    logic           in_cb_reg;
    logic           out_valid_reg;
    sm83_pkg::dec_t out_dec_reg;
    sm83_pkg::dec_t dec;
    logic           out_en;
    logic           in_en;

    assign out_en   = !out_valid_reg || m_tready;
    assign in_en    = !in_valid_reg || out_en;
    assign s_tready = in_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_en) begin
            in_valid_reg <= s_tvalid;
        end
        if (in_en && s_tvalid) begin
            in_op_reg <= s_tdata;
            in_cb_reg <= s_tuser;
        end
    end

    sm83_decode u_decode (
        .opcode_byte (in_op_reg),
        .command     (in_cb_reg),
        .dec         (dec)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_en) begin
            out_valid_reg <= in_valid_reg;
        end
        if (out_en && in_valid_reg) begin
            out_dec_reg <= dec;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_dec_reg.recognized;
    assign m_tdata  = {7'd0,
                       out_dec_reg.bit_or_vector,
                       out_dec_reg.alu_operation,
                       out_dec_reg.condition_sel,
                       out_dec_reg.stack_pair_sel,
                       out_dec_reg.reg16_sel,
                       out_dec_reg.reg8_dest,
                       out_dec_reg.reg8_source,
                       out_dec_reg.reg8_sel,
                       out_dec_reg.machine_cycles,
                       out_dec_reg.length_bytes,
                       out_dec_reg.instr_code};

    a_in_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> in_valid_reg)
        else $error("accepted item not held in input register");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_en |=> in_valid_reg && $stable(in_op_reg)
            && $stable(in_cb_reg))
        else $error("stalled input item lost or changed");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_en |=> m_tvalid)
        else $error("decoded item not moved to result register");

    a_recog_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == (m_tdata[6:0] != sm83_pkg::I_UNKNOWN))
        else $error("recognized flag disagrees with instruction code");

    a_unknown_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[sm83_pkg::TDATA_W-1:12] == '0
            && m_tdata[11:9] == 3'd0 && m_tdata[8:7] == 2'd1)
        else $error("unknown opcode carries operand or timing data");

endmodule

/* rtl/sm83_decode.sv */
// ============================================================================
// sm83_decode
// combinational decode of one opcode byte into code, timing and operands
// ============================================================================
module sm83_decode (
    input  logic              [7:0] opcode_byte,
    input  logic                    command,
    output sm83_pkg::dec_t          dec
);

    logic [7:0]      op;
    logic [1:0]      blk;
    logic [2:0]      mid;
    logic [2:0]      lo3;
    logic [3:0]      lo4;
    sm83_pkg::code_t code;
    sm83_pkg::dec_t  d;

    assign op  = opcode_byte;
    assign blk = op[7:6];
    assign mid = op[5:3];
    assign lo3 = op[2:0];
    assign lo4 = op[3:0];

    always_comb begin
        d    = '0;
        code = sm83_pkg::I_UNKNOWN;
        if (command) begin
            d.reg8_sel = lo3;
            if (blk == 2'd0) begin
                code = sm83_pkg::I_CB_ROT + {4'd0, mid};
            end else begin
                code            = sm83_pkg::I_BIT + {5'd0, blk} - 7'd1;
                d.bit_or_vector = mid;
            end
        end else begin
            unique case (blk)
                2'd0: begin
                    unique case (op)
                        8'h00: code = sm83_pkg::I_NOP;
                        8'h08: code = sm83_pkg::I_LD_N16M_SP;
                        8'h10: code = sm83_pkg::I_STOP;
                        8'h18: code = sm83_pkg::I_JR;
                        8'h07: code = sm83_pkg::I_RLCA;
                        8'h0F: code = sm83_pkg::I_RRCA;
                        8'h17: code = sm83_pkg::I_RLA;
                        8'h1F: code = sm83_pkg::I_RRA;
                        8'h27: code = sm83_pkg::I_DAA;
                        8'h2F: code = sm83_pkg::I_CPL;
                        8'h37: code = sm83_pkg::I_SCF;
                        8'h3F: code = sm83_pkg::I_CCF;
                        default: begin
                            if (lo3 == 3'd0) begin
                                code            = sm83_pkg::I_JR_CC;
                                d.condition_sel = op[4:3];
                            end else if (lo3 == 3'd4) begin
                                code       = sm83_pkg::I_INC_R8;
                                d.reg8_sel = mid;
                            end else if (lo3 == 3'd5) begin
                                code       = sm83_pkg::I_DEC_R8;
                                d.reg8_sel = mid;
                            end else if (lo3 == 3'd6) begin
                                code       = sm83_pkg::I_LD_R8_N8;
                                d.reg8_sel = mid;
                            end else begin
                                d.reg16_sel = op[5:4];
                                unique case (lo4)
                                    4'h1:    code = sm83_pkg::I_LD_R16_N16;
                                    4'hA:    code = sm83_pkg::I_LD_A_R16M;
                                    4'h2:    code = sm83_pkg::I_LD_R16M_A;
                                    4'h3:    code = sm83_pkg::I_INC_R16;
                                    4'hB:    code = sm83_pkg::I_DEC_R16;
                                    default: code = sm83_pkg::I_ADD_HL;
                                endcase
                            end
                        end
                    endcase
                end
                2'd1: begin
                    if (op == sm83_pkg::OP_HALT) begin
                        code = sm83_pkg::I_HALT;
                    end else begin
                        code          = sm83_pkg::I_LD_R8_R8;
                        d.reg8_source = lo3;
                        d.reg8_dest   = mid;
                    end
                end
                2'd2: begin
                    code            = sm83_pkg::I_ALU_R8 + {4'd0, mid};
                    d.alu_operation = mid;
                    d.reg8_sel      = lo3;
                end
                default: begin
                    if ((op & sm83_pkg::MASK_C7) == sm83_pkg::PAT_ALU_N8) begin
                        code = sm83_pkg::I_ALU_N8 + {4'd0, mid};
                    end else if ((op & sm83_pkg::MASK_C7) == sm83_pkg::PAT_RST) begin
                        code            = sm83_pkg::I_RST;
                        d.bit_or_vector = mid;
                    end else if ((op & sm83_pkg::MASK_CF) == sm83_pkg::PAT_POP) begin
                        code             = sm83_pkg::I_POP;
                        d.stack_pair_sel = op[5:4];
                    end else if ((op & sm83_pkg::MASK_CF) == sm83_pkg::PAT_PUSH) begin
                        code             = sm83_pkg::I_PUSH;
                        d.stack_pair_sel = op[5:4];
                    end else begin
                        unique case (op)
                            8'hC0, 8'hC8, 8'hD0, 8'hD8: begin
                                code            = sm83_pkg::I_RET_CC + {5'd0, op[4:3]};
                                d.condition_sel = op[4:3];
                            end
                            8'hC2, 8'hCA, 8'hD2, 8'hDA: begin
                                code            = sm83_pkg::I_JP_CC + {5'd0, op[4:3]};
                                d.condition_sel = op[4:3];
                            end
                            8'hC4, 8'hCC, 8'hD4, 8'hDC: begin
                                code            = sm83_pkg::I_CALL_CC + {5'd0, op[4:3]};
                                d.condition_sel = op[4:3];
                            end
                            8'hC9:   code = sm83_pkg::I_RET;
                            8'hD9:   code = sm83_pkg::I_RETI;
                            8'hC3:   code = sm83_pkg::I_JP;
                            8'hE9:   code = sm83_pkg::I_JP_HL;
                            8'hCD:   code = sm83_pkg::I_CALL;
                            8'hE2:   code = sm83_pkg::I_LDH_CM_A;
                            8'hE0:   code = sm83_pkg::I_LDH_N8M_A;
                            8'hEA:   code = sm83_pkg::I_LD_N16M_A;
                            8'hF2:   code = sm83_pkg::I_LDH_A_CM;
                            8'hF0:   code = sm83_pkg::I_LDH_A_N8M;
                            8'hFA:   code = sm83_pkg::I_LD_A_N16M;
                            8'hE8:   code = sm83_pkg::I_ADD_SP;
                            8'hF8:   code = sm83_pkg::I_LD_HL_SP;
                            8'hF9:   code = sm83_pkg::I_LD_SP_HL;
                            8'hF3:   code = sm83_pkg::I_DI;
                            8'hFB:   code = sm83_pkg::I_EI;
                            default: code = sm83_pkg::I_UNKNOWN;
                        endcase
                    end
                end
            endcase
        end
        d.instr_code     = code;
        d.length_bytes   = sm83_pkg::code_length(code);
        d.machine_cycles = sm83_pkg::code_cycles(code);
        d.recognized     = (code != sm83_pkg::I_UNKNOWN);
    end

    assign dec = d;

endmodule
